@@ hdl/interface_mark_set_macros.svh @@
// Assertion macros for the interface mark set checker.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef INTERFACE_MARK_SET_MACROS_SVH
`define INTERFACE_MARK_SET_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define IMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define IMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ims_pkg.sv @@
// Shared types and constants for the interface mark set.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package ims_pkg;

  localparam int unsigned KEY_W   = 31;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic {
    CMD_MARK   = 1'b0,
    CMD_UNMARK = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_TRIM = 3'b100
  } state_e;

endpackage

@@ hdl/interface_mark_set.sv @@
// Interface mark set: slot table of nonzero keys with a high-water count.
// Depends on ims_pkg.
`timescale 1ns / 1ps

// Usage
//   Command channel: drive command_i and key_i with start_i high; the beat is
//   taken at a rising edge where busy_o is low. For a nonzero key busy_o
//   rises the cycle after. Result channel: done_o is high for exactly one
//   cycle with was_marked_o and used_count_o; the receiver cannot stall it
//   and must take it then. A zero key answers in the next cycle without
//   touching the table. A check reads the slot memory one entry a cycle
//   below the high-water count, then answers; a mark that misses writes
//   its key back if there is room. An unmark that hits stops the scan
//   early, then trims the count one slot a cycle.
//   busy_o is low in the cycle that shows the result, so the next command can
//   be taken there; one item is in flight at a time.
//   Reset clears the high-water count and the per-slot occupancy flags at once;
//   a slot whose flag is clear reads as free, so no clearing pass is needed.
module interface_mark_set
  import ims_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               command_i,
  input  logic [KEY_W-1:0]   key_i,
  output logic               busy_o,
  output logic               done_o,
  output logic               was_marked_o,
  output logic [COUNT_W-1:0] used_count_o
);

  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  state_e            state_q, state_d;
  cmd_e              cmd_q, cmd_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [CW-1:0]     hw_q, hw_d;
  logic [CW-1:0]     rd_idx_q, rd_idx_d;
  logic              rd_vld_q, rd_vld_d;
  logic [IW-1:0]     cmp_idx_q, cmp_idx_d;
  logic              rd_occ_q, rd_occ_d;
  logic              free_fnd_q, free_fnd_d;
  logic [IW-1:0]     free_idx_q, free_idx_d;
  logic              done_q, done_d;
  logic              marked_q, marked_d;
  logic [SLOTS-1:0]  occ_q;

  logic [KEY_W-1:0]  mem_q [SLOTS];
  logic [KEY_W-1:0]  rdata_q;
  logic              mem_re;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [KEY_W-1:0]  mem_wdata;

  logic              hit;
  logic              free_now;
  logic [IW-1:0]     free_at;
  logic [CW-1:0]     hw_m1;
  logic [CW+COUNT_W-1:0] hw_ext;

  assign hit      = rd_vld_q && rd_occ_q && (rdata_q == key_q);
  assign free_now = free_fnd_q || (rd_vld_q && !rd_occ_q);
  assign free_at  = free_fnd_q ? free_idx_q : cmp_idx_q;
  assign hw_m1    = hw_q - 1'b1;
  assign hw_ext   = (CW + COUNT_W)'(hw_q);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    key_d      = key_q;
    hw_d       = hw_q;
    rd_idx_d   = rd_idx_q;
    rd_vld_d   = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    rd_occ_d   = rd_occ_q;
    free_fnd_d = free_fnd_q;
    free_idx_d = free_idx_q;
    done_d     = 1'b0;
    marked_d   = marked_q;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_d      = cmd_e'(command_i);
          key_d      = key_i;
          rd_idx_d   = '0;
          free_fnd_d = 1'b0;
          if (key_i == '0) begin
            // zero means free: never stored or searched; a mark reports it as marked
            done_d   = 1'b1;
            marked_d = (cmd_e'(command_i) == CMD_MARK);
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // read stage
        if (rd_idx_q < hw_q) begin
          mem_re    = 1'b1;
          rd_vld_d  = 1'b1;
          cmp_idx_d = rd_idx_q[IW-1:0];
          rd_occ_d  = occ_q[rd_idx_q[IW-1:0]];
          rd_idx_d  = rd_idx_q + 1'b1;
        end
        // compare stage
        if (rd_vld_q && !rd_occ_q && !free_fnd_q) begin
          free_fnd_d = 1'b1;
          free_idx_d = cmp_idx_q;
        end
        if (hit) begin
          rd_vld_d = 1'b0;
          if (cmd_q == CMD_MARK) begin
            done_d   = 1'b1;
            marked_d = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = cmp_idx_q;
            state_d   = ST_TRIM;
          end
        end else if (rd_idx_q >= hw_q) begin
          // scan exhausted
          state_d = ST_IDLE;
          done_d  = 1'b1;
          if (cmd_q == CMD_UNMARK) begin
            marked_d = 1'b0;
          end else if (free_now) begin
            mem_we    = 1'b1;
            mem_waddr = free_at;
            mem_wdata = key_q;
            marked_d  = 1'b0;
          end else if (hw_q < CW'(SLOTS)) begin
            mem_we    = 1'b1;
            mem_waddr = hw_q[IW-1:0];
            mem_wdata = key_q;
            hw_d      = hw_q + 1'b1;
            marked_d  = 1'b0;
          end else begin
            marked_d = 1'b1;
          end
        end
      end

      ST_TRIM: begin
        if ((hw_q != '0) && !occ_q[hw_m1[IW-1:0]]) begin
          hw_d = hw_m1;
        end else begin
          state_d  = ST_IDLE;
          done_d   = 1'b1;
          marked_d = 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      hw_q       <= '0;
      rd_vld_q   <= 1'b0;
      done_q     <= 1'b0;
      occ_q      <= '0;
    end else begin
      state_q  <= state_d;
      hw_q     <= hw_d;
      rd_vld_q <= rd_vld_d;
      done_q   <= done_d;
      if (mem_we) begin
        occ_q[mem_waddr] <= (mem_wdata != '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    rd_idx_q   <= rd_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    rd_occ_q   <= rd_occ_d;
    free_fnd_q <= free_fnd_d;
    free_idx_q <= free_idx_d;
    marked_q   <= marked_d;
  end

  // slot store, one read and one write port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[rd_idx_q[IW-1:0]];
    end
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign was_marked_o = marked_q;
  assign used_count_o = hw_ext[COUNT_W-1:0];

endmodule

@@ hdl/ims_checker.sv @@
// Port-level checker for the interface mark set, bound to the top level.
// Depends on ims_pkg and interface_mark_set_macros.svh.
`timescale 1ns / 1ps
`include "interface_mark_set_macros.svh"

module ims_checker
  import ims_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               command_i,
  input logic [KEY_W-1:0]   key_i,
  input logic               busy_o,
  input logic               done_o,
  input logic               was_marked_o,
  input logic [COUNT_W-1:0] used_count_o
);

  logic take;
  assign take = start_i && !busy_o;

  `IMS_ASSERT_NOW(a_count_cap, done_o && (SLOTS < 32), 32'(used_count_o) <= SLOTS, "count beyond capacity")
  `IMS_ASSERT_NOW(a_done_idle, done_o, !busy_o, "result shown while busy")
  `IMS_ASSERT_NEXT(a_zero_key, take && (key_i == '0), done_o && !busy_o && (was_marked_o == ($past(command_i) == CMD_MARK)), "zero key answered wrongly")
  `IMS_ASSERT_NEXT(a_busy_after, take && (key_i != '0), busy_o && !done_o, "nonzero key not taken up")

endmodule

bind interface_mark_set ims_checker #(.SLOTS(SLOTS)) u_ims_checker (.*);

@@ tb/interface_mark_set_test.sv @@
// Self-checking testbench for interface_mark_set: directed then random beats
// against a shadow copy of the key table. Depends on ims_pkg and the RTL.
`timescale 1ns / 1ps

module interface_mark_set_test;
  import ims_pkg::*;

  localparam int unsigned SLOTS      = 16;
  localparam int unsigned POOL       = 24;
  localparam int unsigned RAND_BEATS = 1930;
  localparam int unsigned LIMIT      = 1000000;
  localparam int unsigned DRAIN      = 2 * SLOTS + 8;

  typedef struct packed {
    logic               marked;
    logic [COUNT_W-1:0] count;
  } answer_t;

  // Shadow of the key table; predicts the answer of each accepted beat.
  class mark_set_shadow;
    logic [KEY_W-1:0] slot_key [SLOTS];
    int unsigned      high_water;
    answer_t          answers [$];
    int unsigned      errors;

    function new();
      foreach (slot_key[i]) slot_key[i] = '0;
      high_water = 0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return answers.size();
    endfunction

    function void note_command(cmd_e cmd, logic [KEY_W-1:0] key);
      answer_t     a;
      int unsigned free_at;
      logic        hit;
      hit = 1'b0;
      free_at = high_water;
      if (cmd == CMD_MARK) begin
        if (key == '0) begin
          hit = 1'b1;
        end else begin
          for (int unsigned i = 0; i < high_water; i++) begin
            if (slot_key[i] == key) hit = 1'b1;
            if (slot_key[i] == '0 && free_at == high_water) free_at = i;
          end
          if (!hit) begin
            if (free_at < high_water) begin
              slot_key[free_at] = key;
            end else if (high_water >= SLOTS) begin
              hit = 1'b1;  // full: refused, reported as marked
            end else begin
              slot_key[high_water] = key;
              high_water++;
            end
          end
        end
      end else if (key != '0) begin
        for (int unsigned i = 0; i < high_water; i++) begin
          if (!hit && slot_key[i] == key) begin
            slot_key[i] = '0;
            hit = 1'b1;
          end
        end
        while (high_water > 0 && slot_key[high_water-1] == '0) high_water--;
      end
      a.marked = hit;
      a.count  = COUNT_W'(high_water);
      answers.push_back(a);
    endfunction

    function void check_result(logic marked, logic [COUNT_W-1:0] count);
      answer_t a;
      if (answers.size() == 0) begin
        $error("result beat with nothing outstanding: was_marked=%0b used_count=%0d",
               marked, count);
        errors++;
        return;
      end
      a = answers.pop_front();
      if (marked !== a.marked) begin
        $error("was_marked: expected %0b, got %0b", a.marked, marked);
        errors++;
      end
      if (count !== a.count) begin
        $error("used_count: expected %0d, got %0d", a.count, count);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               start_i   = 1'b0;
  logic               command_i = 1'b0;
  logic [KEY_W-1:0]   key_i     = '0;
  logic               busy_o;
  logic               done_o;
  logic               was_marked_o;
  logic [COUNT_W-1:0] used_count_o;

  mark_set_shadow     shadow = new();
  logic [KEY_W-1:0]   key_pool [POOL];
  int unsigned        cycle_count = 0;

  interface_mark_set #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .command_i   (command_i),
    .key_i       (key_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .was_marked_o(was_marked_o),
    .used_count_o(used_count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Result first: it belongs to the beat taken earlier.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) shadow.check_result(was_marked_o, used_count_o);
      if (start_i && !busy_o) shadow.note_command(cmd_e'(command_i), key_i);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Present one beat and return at the edge that takes it.
  task automatic send_beat(input cmd_e cmd, input logic [KEY_W-1:0] key);
    start_i   <= 1'b1;
    command_i <= cmd;
    key_i     <= key;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic idle_gap(input int unsigned percent);
    while ($urandom_range(0, 99) < percent) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (shadow.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned      r;
    logic [KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 80) return key_pool[$urandom_range(0, POOL - 1)];
    if (r == 99) return '0;
    k = KEY_W'($urandom);
    return (k == '0) ? KEY_W'(1) : k;
  endfunction

  initial begin
    int unsigned mark_pct;
    int unsigned gap_pct;

    key_pool[0] = KEY_W'(1);
    key_pool[1] = '1;
    key_pool[2] = KEY_W'(1) << (KEY_W - 1);
    for (int i = 3; i < POOL; i++) begin
      key_pool[i] = KEY_W'($urandom);
      if (key_pool[i] == '0) key_pool[i] = KEY_W'(i);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, hit, zero key, absent unmark, hole reuse, full table.
    send_beat(CMD_MARK, KEY_W'(1));
    send_beat(CMD_MARK, '1);
    send_beat(CMD_MARK, KEY_W'(1));
    send_beat(CMD_MARK, '0);
    send_beat(CMD_UNMARK, '0);
    send_beat(CMD_UNMARK, KEY_W'(5));
    send_beat(CMD_UNMARK, KEY_W'(1));
    send_beat(CMD_MARK, KEY_W'(31'h5555_5555));
    for (int i = 0; i < SLOTS - 2; i++) send_beat(CMD_MARK, KEY_W'(100 + i));
    send_beat(CMD_MARK, KEY_W'(31'h2AAA_AAAA));
    send_beat(CMD_UNMARK, KEY_W'(100 + SLOTS - 3));
    send_beat(CMD_UNMARK, '1);
    wait_drained();

    mark_pct = 85;
    for (int n = 0; n < RAND_BEATS; n++) begin
      // Swing between filling and draining the table.
      if (n % 150 == 0) begin
        case ($urandom_range(0, 2))
          0: mark_pct = 85;
          1: mark_pct = 50;
          default: mark_pct = 20;
        endcase
      end
      gap_pct = (n >= 700 && n < 1100) ? 0 : 10;
      if (n == 1300) wait_drained();
      idle_gap(gap_pct);
      send_beat(($urandom_range(0, 99) < mark_pct) ? CMD_MARK : CMD_UNMARK, pick_key());
    end
    start_i <= 1'b0;

    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
